[hw/rtl/csdt_pkg.sv]
// Shared types and constants of the collection slot due time block.
// Holds the mixer constants, register indexes and the divider transaction
// structs; no dependencies.
`timescale 1ns / 1ps
`default_nettype none

package csdt_pkg;

   localparam int unsigned WORD_WIDTH  = 32;
   localparam int unsigned COUNT_WIDTH = 16;
   localparam int unsigned IDENT_WIDTH = 64;

   localparam logic [WORD_WIDTH-1:0] MIX_MUL_A = 32'h7feb352d;
   localparam logic [WORD_WIDTH-1:0] MIX_MUL_B = 32'h846ca68b;

   localparam int unsigned CSR_INDEX_WIDTH = 8;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_SPREAD_PER_NODE = 8'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_MIN_SPREAD      = 8'd1;

   localparam logic [COUNT_WIDTH-1:0] SPREAD_RESET     = 16'd10;
   localparam logic [WORD_WIDTH-1:0]  MIN_SPREAD_RESET = 32'd1000;

   // transaction into the remainder pipeline
   typedef struct packed {
      logic [WORD_WIDTH-1:0] dividend;
      logic [WORD_WIDTH-1:0] divisor;
      logic [WORD_WIDTH-1:0] flood_end;
   } csdt_mod_req_type;

   // transaction out of the remainder pipeline
   typedef struct packed {
      logic [WORD_WIDTH-1:0] remainder;
      logic                  divisor_zero;
      logic [WORD_WIDTH-1:0] flood_end;
   } csdt_mod_rsp_type;

endpackage

`default_nettype wire

[hw/rtl/csdt_mod_pipe.sv]
// Pipelined restoring remainder unit: one dividend bit per stage.
// Depends on csdt_pkg for widths and transaction structs.
`timescale 1ns / 1ps
`default_nettype none

module csdt_mod_pipe
   import csdt_pkg::*;
(
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             in_valid,
   output logic                  in_ready,
   input  wire csdt_mod_req_type in_data,
   output logic                  out_valid,
   input  wire logic             out_ready,
   output csdt_mod_rsp_type      out_data
);

   localparam int unsigned STAGES = WORD_WIDTH;

   typedef struct packed {
      logic [WORD_WIDTH-1:0] rem;
      logic [WORD_WIDTH-1:0] dvd;
      logic [WORD_WIDTH-1:0] dsr;
      logic [WORD_WIDTH-1:0] flood;
   } stage_type;

   logic [STAGES-1:0] valid_ff;
   logic [STAGES-1:0] ready;
   stage_type         stage_ff [STAGES];
   stage_type         stage_in [STAGES];

   genvar k;
   generate
      for (k = 0; k < STAGES; k++) begin : g_stage
         logic              prev_valid;
         stage_type         prev;
         logic [WORD_WIDTH:0] trial;

         if (k == 0) begin : g_first
            assign prev_valid = in_valid;
            assign prev.rem   = '0;
            assign prev.dvd   = in_data.dividend;
            assign prev.dsr   = in_data.divisor;
            assign prev.flood = in_data.flood_end;
         end else begin : g_next
            assign prev_valid = valid_ff[k-1];
            assign prev       = stage_ff[k-1];
         end

         if (k == STAGES - 1) begin : g_last_rdy
            assign ready[k] = !valid_ff[k] || out_ready;
         end else begin : g_mid_rdy
            assign ready[k] = !valid_ff[k] || ready[k+1];
         end

         // shift in the next dividend bit, subtract when it fits
         always_comb begin
            trial = {prev.rem, prev.dvd[WORD_WIDTH-1]};
            if (trial >= {1'b0, prev.dsr}) begin
               trial = trial - {1'b0, prev.dsr};
            end
            stage_in[k].rem   = trial[WORD_WIDTH-1:0];
            stage_in[k].dvd   = {prev.dvd[WORD_WIDTH-2:0], 1'b0};
            stage_in[k].dsr   = prev.dsr;
            stage_in[k].flood = prev.flood;
         end

         always_ff @(posedge clock) begin
            if (reset) begin
               valid_ff[k] <= 1'b0;
            end else if (ready[k]) begin
               valid_ff[k] <= prev_valid;
            end
         end

         always_ff @(posedge clock) begin
            if (ready[k] && prev_valid) begin
               stage_ff[k] <= stage_in[k];
            end
         end

         a_rem_bound: assert property (@(posedge clock) disable iff (reset)
            valid_ff[k] && (stage_ff[k].dsr != '0) |-> stage_ff[k].rem < stage_ff[k].dsr)
            else $error("stage remainder not below divisor");
      end
   endgenerate

   assign in_ready              = ready[0];
   assign out_valid             = valid_ff[STAGES-1];
   assign out_data.remainder    = stage_ff[STAGES-1].rem;
   assign out_data.divisor_zero = (stage_ff[STAGES-1].dsr == '0);
   assign out_data.flood_end    = stage_ff[STAGES-1].flood;

   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      valid_ff[STAGES-1] && !out_ready |-> !ready[STAGES-1])
      else $error("last stage accepts while stalled");

   a_dividend_drained: assert property (@(posedge clock) disable iff (reset)
      valid_ff[STAGES-1] |-> stage_ff[STAGES-1].dvd == '0)
      else $error("dividend bits left at the last stage");

endmodule

`default_nettype wire

[hw/rtl/collection_slot_due_time.sv]
// Top level of the collection slot due time block: hash, window and output.
// Depends on csdt_pkg and csdt_mod_pipe.
//
// Usage:
//   req_*  : one transaction per node response; tdata carries flood end,
//            node id, sequence number, slot seed and node count.
//   rsp_*  : one transaction per request, carrying due_ms.
//   csr_*  : register writes (spread per node, minimum spread), taken at
//            any edge with csr_wr_en high; write only while idle.
// The window is node_count * spread_per_node_ms raised to min_spread_ms.
// The xor of sequence, seed and both id halves goes through the lowbias32
// mixer; due_ms = flood_end_ms + (hash mod window), or flood_end_ms when
// the window is zero.
// Throughput: one transaction per cycle while the receiver takes results. The path
// is four stages for the mixer multiplies and window, 32 stages of the
// one-bit-per-stage remainder pipeline, and the output register.
// Each stage holds its transaction while the next one is full, so when the
// receiver stalls the pipeline fills up behind the output register and
// req_tready drops only once every stage is occupied. Nothing is lost.
// Reset clears all valid bits and loads the register reset values.
`timescale 1ns / 1ps
`default_nettype none

module collection_slot_due_time
   import csdt_pkg::*;
(
   input  wire logic                       clock,
   input  wire logic                       reset,
   // req_tdata, lowest bit up: flood_end_ms[32], node_ident[64],
   // sequence_number[32], slot_seed[32], node_count[16]
   input  wire logic                       req_tvalid,
   output logic                            req_tready,
   input  wire logic [175:0]               req_tdata,
   // rsp_tdata, lowest bit up: due_ms[32]
   output logic                            rsp_tvalid,
   input  wire logic                       rsp_tready,
   output logic [31:0]                     rsp_tdata,
   input  wire logic                       csr_wr_en,
   input  wire logic [CSR_INDEX_WIDTH-1:0] csr_index,
   input  wire logic [WORD_WIDTH-1:0]      csr_wdata
);

   // unpack the request
   logic [WORD_WIDTH-1:0]  req_flood;
   logic [IDENT_WIDTH-1:0] req_ident;
   logic [WORD_WIDTH-1:0]  req_seq;
   logic [WORD_WIDTH-1:0]  req_seed;
   logic [COUNT_WIDTH-1:0] req_count;

   assign req_flood = req_tdata[31:0];
   assign req_ident = req_tdata[95:32];
   assign req_seq   = req_tdata[127:96];
   assign req_seed  = req_tdata[159:128];
   assign req_count = req_tdata[175:160];

   // configuration registers
   logic [COUNT_WIDTH-1:0] spread_ff;
   logic [WORD_WIDTH-1:0]  min_spread_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         spread_ff     <= SPREAD_RESET;
         min_spread_ff <= MIN_SPREAD_RESET;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            CSR_SPREAD_PER_NODE: spread_ff     <= csr_wdata[COUNT_WIDTH-1:0];
            CSR_MIN_SPREAD:      min_spread_ff <= csr_wdata;
            default: ;  // drop writes to unknown indexes
         endcase
      end
   end

   // stage handshake
   logic s1_valid_ff, s2_valid_ff, s3_valid_ff, s4_valid_ff;
   logic s1_ready, s2_ready, s3_ready, s4_ready;
   logic mod_in_ready;
   logic mod_out_valid;
   logic mod_out_ready;
   csdt_mod_req_type mod_req;
   csdt_mod_rsp_type mod_rsp;

   assign s4_ready   = !s4_valid_ff || mod_in_ready;
   assign s3_ready   = !s3_valid_ff || s4_ready;
   assign s2_ready   = !s2_valid_ff || s3_ready;
   assign s1_ready   = !s1_valid_ff || s2_ready;
   assign req_tready = s1_ready;

   // stage 1: fold the key, first xor-shift, window product
   logic [WORD_WIDTH-1:0] key;
   logic [WORD_WIDTH-1:0] s1_hash_ff, s1_hash_in;
   logic [WORD_WIDTH-1:0] s1_prod_ff, s1_prod_in;
   logic [WORD_WIDTH-1:0] s1_flood_ff;

   always_comb begin
      key        = req_seq ^ req_seed ^ req_ident[31:0] ^ req_ident[63:32];
      s1_hash_in = key ^ (key >> 16);
      s1_prod_in = {16'b0, req_count} * {16'b0, spread_ff};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (s1_ready) begin
         s1_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_ready && req_tvalid) begin
         s1_hash_ff  <= s1_hash_in;
         s1_prod_ff  <= s1_prod_in;
         s1_flood_ff <= req_flood;
      end
   end

   // stage 2: first multiply, clamp the window to the minimum
   logic [WORD_WIDTH-1:0] s2_hash_ff, s2_hash_in;
   logic [WORD_WIDTH-1:0] s2_window_ff, s2_window_in;
   logic [WORD_WIDTH-1:0] s2_flood_ff;

   always_comb begin
      s2_hash_in   = s1_hash_ff * MIX_MUL_A;
      s2_window_in = (s1_prod_ff < min_spread_ff) ? min_spread_ff : s1_prod_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else if (s2_ready) begin
         s2_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (s2_ready && s1_valid_ff) begin
         s2_hash_ff   <= s2_hash_in;
         s2_window_ff <= s2_window_in;
         s2_flood_ff  <= s1_flood_ff;
      end
   end

   // stage 3: second xor-shift and multiply
   logic [WORD_WIDTH-1:0] s3_mix;
   logic [WORD_WIDTH-1:0] s3_hash_ff, s3_hash_in;
   logic [WORD_WIDTH-1:0] s3_window_ff;
   logic [WORD_WIDTH-1:0] s3_flood_ff;

   always_comb begin
      s3_mix     = s2_hash_ff ^ (s2_hash_ff >> 15);
      s3_hash_in = s3_mix * MIX_MUL_B;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_valid_ff <= 1'b0;
      end else if (s3_ready) begin
         s3_valid_ff <= s2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (s3_ready && s2_valid_ff) begin
         s3_hash_ff   <= s3_hash_in;
         s3_window_ff <= s2_window_ff;
         s3_flood_ff  <= s2_flood_ff;
      end
   end

   // stage 4: final xor-shift, hand to the remainder pipeline
   logic [WORD_WIDTH-1:0] s4_hash_ff, s4_hash_in;
   logic [WORD_WIDTH-1:0] s4_window_ff;
   logic [WORD_WIDTH-1:0] s4_flood_ff;

   assign s4_hash_in = s3_hash_ff ^ (s3_hash_ff >> 16);

   always_ff @(posedge clock) begin
      if (reset) begin
         s4_valid_ff <= 1'b0;
      end else if (s4_ready) begin
         s4_valid_ff <= s3_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (s4_ready && s3_valid_ff) begin
         s4_hash_ff   <= s4_hash_in;
         s4_window_ff <= s3_window_ff;
         s4_flood_ff  <= s3_flood_ff;
      end
   end

   assign mod_req.dividend  = s4_hash_ff;
   assign mod_req.divisor   = s4_window_ff;
   assign mod_req.flood_end = s4_flood_ff;

   csdt_mod_pipe u_mod (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (s4_valid_ff),
      .in_ready  (mod_in_ready),
      .in_data   (mod_req),
      .out_valid (mod_out_valid),
      .out_ready (mod_out_ready),
      .out_data  (mod_rsp)
   );

   // output register: add the offset, zero window gives no offset
   logic                  rsp_valid_ff;
   logic [WORD_WIDTH-1:0] rsp_due_ff, rsp_due_in;

   assign mod_out_ready = !rsp_valid_ff || rsp_tready;
   assign rsp_due_in    = mod_rsp.flood_end
                        + (mod_rsp.divisor_zero ? '0 : mod_rsp.remainder);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (mod_out_ready) begin
         rsp_valid_ff <= mod_out_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (mod_out_ready && mod_out_valid) begin
         rsp_due_ff <= rsp_due_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_due_ff;

   a_window_floor: assert property (@(posedge clock) disable iff (reset)
      s4_valid_ff |-> s4_window_ff >= min_spread_ff)
      else $error("window below minimum spread");

   a_out_stall: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_tready |=> rsp_valid_ff)
      else $error("output register emptied while stalled");

   a_fill_stall: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && s2_valid_ff && s3_valid_ff && s4_valid_ff && !mod_in_ready
      |-> !req_tready)
      else $error("input accepted with all hash stages blocked");

endmodule

`default_nettype wire

[tb/collection_slot_due_time_tb.sv]
// Self-checking bench for collection_slot_due_time: streams node reports,
// predicts each due time with a local hash-and-window model and compares.
// Depends on csdt_pkg and the collection_slot_due_time RTL.
`timescale 1ns / 1ps

module collection_slot_due_time_tb;
   import csdt_pkg::*;

   // Pipeline depth given by the block: mixer stages, remainder stages, output.
   localparam int PIPE_LATENCY = 37;
   // Register index that maps to nothing; writes to it must be dropped.
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_UNMAPPED = 8'hff;

   // One node report as it sits on req_tdata; the last member is the lowest bits.
   typedef struct packed {
      logic [COUNT_WIDTH-1:0] node_count;
      logic [WORD_WIDTH-1:0]  slot_seed;
      logic [WORD_WIDTH-1:0]  sequence_number;
      logic [IDENT_WIDTH-1:0] node_ident;
      logic [WORD_WIDTH-1:0]  flood_end_ms;
   } node_report_type;

   logic                       clock = 1'b0;
   logic                       reset = 1'b1;
   logic                       req_tvalid = 1'b0;
   logic                       req_tready;
   logic [175:0]               req_tdata = '0;
   logic                       rsp_tvalid;
   logic                       rsp_tready = 1'b0;
   logic [31:0]                rsp_tdata;
   logic                       csr_wr_en = 1'b0;
   logic [CSR_INDEX_WIDTH-1:0] csr_index = '0;
   logic [WORD_WIDTH-1:0]      csr_wdata = '0;

   // Local copy of the two registers, kept in step with every write.
   logic [COUNT_WIDTH-1:0]     spread_per_node_ms;
   logic [WORD_WIDTH-1:0]      min_spread_ms;

   // Due times still owed by the block, oldest first.
   logic [31:0]                pending_due_q[$];
   int                         mismatch_count = 0;

   // Percent of cycles the sender idles and the receiver stalls.
   int                         send_idle_pct = 0;
   int                         rsp_stall_pct = 0;

   collection_slot_due_time uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_wr_en  (csr_wr_en),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always #10 clock = ~clock;

   // Window from node count, hash of the id fields, then offset from flood end.
   function automatic logic [31:0] predict_due_ms(node_report_type rpt);
      logic [31:0] window;
      logic [31:0] mix;
      logic [31:0] offset;
      window = rpt.node_count * spread_per_node_ms;
      if (window < min_spread_ms) begin
         window = min_spread_ms;
      end
      mix = rpt.sequence_number ^ rpt.slot_seed
            ^ rpt.node_ident[31:0] ^ rpt.node_ident[63:32];
      mix = mix ^ (mix >> 16);
      mix = mix * MIX_MUL_A;
      mix = mix ^ (mix >> 15);
      mix = mix * MIX_MUL_B;
      mix = mix ^ (mix >> 16);
      // A zero window can only come from out-of-range writes; no offset then.
      offset = (window != 0) ? mix % window : 32'd0;
      return rpt.flood_end_ms + offset;
   endfunction

   function automatic node_report_type make_report(logic [31:0] flood_end, logic [63:0] ident,
                                                   logic [31:0] seq_num, logic [31:0] seed,
                                                   logic [15:0] count);
      node_report_type rpt;
      rpt.flood_end_ms    = flood_end;
      rpt.node_ident      = ident;
      rpt.sequence_number = seq_num;
      rpt.slot_seed       = seed;
      rpt.node_count      = count;
      return rpt;
   endfunction

   // Full-range fields; node count is often small so the minimum window matters.
   function automatic node_report_type random_report();
      logic [15:0] count;
      if ($urandom_range(1) == 0) begin
         count = 16'($urandom_range(300));
      end else begin
         count = 16'($urandom);
      end
      return make_report($urandom, {$urandom, $urandom}, $urandom, $urandom, count);
   endfunction

   // Receiver: stall at the phase's rate, re-drawn every cycle.
   always @(posedge clock) begin
      rsp_tready <= ($urandom_range(99) >= rsp_stall_pct);
   end

   // Result checker: every accepted transaction pops the oldest due time.
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_due_q.size() == 0) begin
            $error("due_ms: result with none pending, actual %h", rsp_tdata);
            mismatch_count++;
         end else begin
            logic [31:0] due_exp;
            due_exp = pending_due_q.pop_front();
            if (rsp_tdata[31:0] !== due_exp) begin
               $error("due_ms: expected %h, actual %h", due_exp, rsp_tdata[31:0]);
               mismatch_count++;
            end
         end
      end
   end

   // Offer one report, idling first at the phase's rate; valid stays high
   // after acceptance so back-to-back transactions need no extra edge.
   task automatic send_report(node_report_type rpt);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= rpt;
      do begin
         @(posedge clock);
      end while (!req_tready);
      pending_due_q.push_back(predict_due_ms(rpt));
   endtask

   // Drop valid and hold until every due time is back, plus the pipe depth.
   task automatic wait_for_results();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending_due_q.size() != 0) begin
         @(posedge clock);
      end
      repeat (PIPE_LATENCY + 3) @(posedge clock);
   endtask

   // Register write, one edge wide; call only with the block idle.
   task automatic write_csr(logic [CSR_INDEX_WIDTH-1:0] index, logic [WORD_WIDTH-1:0] data);
      csr_wr_en <= 1'b1;
      csr_index <= index;
      csr_wdata <= data;
      @(posedge clock);
      if (index == CSR_SPREAD_PER_NODE) begin
         spread_per_node_ms = data[COUNT_WIDTH-1:0];
      end else if (index == CSR_MIN_SPREAD) begin
         min_spread_ms = data;
      end
      csr_wr_en <= 1'b0;
      @(posedge clock);
   endtask

   // Reset values: boundary where the product meets the minimum, all-zero and
   // all-one fields, flood end wrap, and id halves that cancel in the xor.
   task automatic test_reset_defaults();
      send_report(make_report(32'h0, 64'h0, 32'h0, 32'h0, 16'h0));
      send_report(make_report('1, '1, '1, '1, '1));
      send_report(make_report($urandom, {$urandom, $urandom}, $urandom, $urandom, 16'd100));
      send_report(make_report($urandom, {$urandom, $urandom}, $urandom, $urandom, 16'd101));
      send_report(make_report(32'hffff_ffff, 64'h0123_4567_89ab_cdef, $urandom, $urandom, 16'd0));
      send_report(make_report(32'h8000_0000, 64'h1234_5678_1234_5678, 32'h0, 32'h0, 16'd7));
      wait_for_results();
   endtask

   // Register extremes, out-of-range zero values, unmapped index, masking.
   task automatic test_window_extremes();
      // largest product, smallest minimum
      write_csr(CSR_SPREAD_PER_NODE, 32'd65535);
      write_csr(CSR_MIN_SPREAD, 32'd1);
      send_report(make_report($urandom, {$urandom, $urandom}, $urandom, $urandom, 16'hffff));
      send_report(make_report('1, {$urandom, $urandom}, $urandom, $urandom, 16'd0));
      send_report(make_report($urandom, {$urandom, $urandom}, $urandom, $urandom, 16'd1));
      wait_for_results();

      // minimum above any product
      write_csr(CSR_MIN_SPREAD, 32'hffff_ffff);
      send_report(make_report($urandom, {$urandom, $urandom}, $urandom, $urandom, 16'hffff));
      send_report(make_report('1, '1, '1, '1, '1));
      wait_for_results();

      // zero per-node spread: window falls back to the minimum
      write_csr(CSR_SPREAD_PER_NODE, 32'd0);
      write_csr(CSR_MIN_SPREAD, 32'd5000);
      send_report(make_report($urandom, {$urandom, $urandom}, $urandom, $urandom, 16'hffff));
      wait_for_results();

      // zero window: due time is the flood end itself
      write_csr(CSR_MIN_SPREAD, 32'd0);
      send_report(make_report('1, {$urandom, $urandom}, $urandom, $urandom, 16'hffff));
      send_report(make_report($urandom, {$urandom, $urandom}, $urandom, $urandom, 16'd3));
      wait_for_results();

      // unmapped index must leave both registers alone
      write_csr(CSR_UNMAPPED, 32'h0000_1234);
      send_report(make_report($urandom, {$urandom, $urandom}, $urandom, $urandom, 16'd9));
      wait_for_results();

      // upper half of a spread write is dropped
      write_csr(CSR_SPREAD_PER_NODE, 32'hffff_0003);
      write_csr(CSR_MIN_SPREAD, 32'd2);
      send_report(make_report($urandom, {$urandom, $urandom}, $urandom, $urandom, 16'd1234));
      send_report(make_report($urandom, {$urandom, $urandom}, $urandom, $urandom, 16'hffff));
      wait_for_results();
   endtask

   // Random reports under one register setting and one idle profile;
   // optionally pause halfway until the block has fully drained.
   task automatic test_random_phase(int idle_pct, int stall_pct, logic [31:0] spread,
                                    logic [31:0] min_spread, int n_reports, bit hold_midway);
      write_csr(CSR_SPREAD_PER_NODE, spread);
      write_csr(CSR_MIN_SPREAD, min_spread);
      send_idle_pct = idle_pct;
      rsp_stall_pct = stall_pct;
      for (int i = 0; i < n_reports; i++) begin
         if (hold_midway && i == n_reports / 2) begin
            wait_for_results();
         end
         send_report(random_report());
      end
      wait_for_results();
   endtask

   initial begin
      spread_per_node_ms = SPREAD_RESET;
      min_spread_ms      = MIN_SPREAD_RESET;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_reset_defaults();
      test_window_extremes();
      // no idling, moderate random setting
      test_random_phase(0, 0, $urandom_range(1, 65535), $urandom_range(1, 100000), 120, 1'b0);
      // sender idle; smallest legal registers
      test_random_phase(57, 0, 32'd1, 32'd1, 120, 1'b0);
      // receiver stalls; largest registers, with a full drain halfway
      test_random_phase(0, 57, 32'd65535, 32'hffff_ffff, 120, 1'b1);
      // both sides idle a little; full-range minimum
      test_random_phase(9, 9, $urandom_range(1, 65535), $urandom, 120, 1'b0);

      if (mismatch_count == 0) begin
         $display("collection_slot_due_time: match");
      end else begin
         $display("collection_slot_due_time: mismatch");
      end
      $finish;
   end

   // Hang guard, far beyond the slowest correct run.
   initial begin
      #4_000_000;
      $display("collection_slot_due_time: mismatch");
      $finish;
   end

endmodule
